/* sv/rsi_pkg.sv */
// shared widths, constants and types for the ray/sphere intersection pipeline
package rsi_pkg;

    localparam int CW    = 32;
    localparam int FB    = 16;
    localparam int EPS_W = 16;

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd66;

    // front end: oc = origin - center, dot products
    localparam int OCW   = CW + 1;
    localparam int AW    = 2 * CW;
    localparam int ODW   = OCW + CW;
    localparam int HW    = 2 * CW + 2;
    localparam int HMW   = 2 * CW + 1;
    localparam int OOW   = 2 * OCW;
    localparam int DIAMW = CW - 1;
    localparam int DSQW  = 2 * CW - 2;

    // wide multiplier split into partial products
    localparam int MW    = 2 * CW + 2;
    localparam int MNCH  = 3;
    localparam int MCH   = (MW + MNCH - 1) / MNCH;
    localparam int MPW   = 2 * MW;

    // discriminant and square root
    localparam int QW    = 4 * CW + 6;
    localparam int TW    = QW + 2 * FB;
    localparam int RW    = TW / 2;
    localparam int RMW   = RW + 2;

    // root numerators, threshold and divider
    localparam int NW    = HMW + FB + 1;
    localparam int NUMW  = ((NW > RW) ? NW : RW) + 1;
    localparam int DENW  = AW + 1;
    localparam int DLO   = 32;
    localparam int DHI   = DENW - DLO;
    localparam int THW   = EPS_W + 1 + DENW;
    localparam int CMPW  = (THW > NUMW) ? THW : NUMW;
    localparam int QTW   = CW - 1;
    localparam int DVW   = ((DENW + QTW) > NUMW) ? (DENW + QTW) : NUMW;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_EPS = '0;

    localparam logic [CW-1:0] ONE_Q     = {{(CW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
    localparam logic [CW-1:0] MISS_DIST = ~ONE_Q + 1'b1;
    localparam logic [CW-1:0] MAX_DIST  = {1'b0, {(CW-1){1'b1}}};

    typedef struct packed {
        logic           ok;
        logic           xpos;
        logic [HMW-1:0] hm;
        logic [AW-1:0]  a;
    } rsi_side_t;

endpackage

/* sv/ray_sphere_intersect.sv */
// ray/sphere intersection test, fully pipelined, one ray per cycle while not stalled
//
//  channel   handshake               payload
//  request   req_valid / req_stall   origin_*, dir_*, center_*, diameter
//  response  rsp_valid / rsp_stall   hit, distance
//  config    psel/penable/pready     epsilon at paddr 0-3
//
// one transaction enters per cycle while req_stall is low
// the path runs through the 83-stage square root and the 32-stage quotient pipeline
// reset clears all valid bits and sets epsilon to 66; payload registers are not reset
// a held result fills a one-entry skid register, after which req_stall rises
// and the whole pipeline freezes until the output is taken
module ray_sphere_intersect import rsi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic signed [CW-1:0] origin_x,
    input  logic signed [CW-1:0] origin_y,
    input  logic signed [CW-1:0] origin_z,
    input  logic signed [CW-1:0] dir_x,
    input  logic signed [CW-1:0] dir_y,
    input  logic signed [CW-1:0] dir_z,
    input  logic signed [CW-1:0] center_x,
    input  logic signed [CW-1:0] center_y,
    input  logic signed [CW-1:0] center_z,
    input  logic [DIAMW-1:0]     diameter,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic                 hit,
    output logic signed [CW-1:0] distance,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    logic             en;
    logic [EPS_W-1:0] eps_reg;
    logic             eps_sel;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign eps_sel = paddr[PADDR_W-1:2] == REG_EPS;
    assign prdata  = eps_sel ? PDATA_W'(eps_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (psel && penable && pwrite && pready && eps_sel)
        begin
            eps_reg <= pwdata[EPS_W-1:0];
        end
    end

    // ---------------- stage 1: oc = origin - center ----------------
    logic signed [CW-1:0]  o_in [3];
    logic signed [CW-1:0]  d_in [3];
    logic signed [CW-1:0]  c_in [3];
    logic signed [OCW-1:0] oc_next [3];

    assign o_in[0] = origin_x;
    assign o_in[1] = origin_y;
    assign o_in[2] = origin_z;
    assign d_in[0] = dir_x;
    assign d_in[1] = dir_y;
    assign d_in[2] = dir_z;
    assign c_in[0] = center_x;
    assign c_in[1] = center_y;
    assign c_in[2] = center_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            oc_next[i] = OCW'(o_in[i]) - OCW'(c_in[i]);
        end
    end

    logic                  s1_v_reg;
    logic signed [OCW-1:0] s1_oc_reg [3];
    logic signed [CW-1:0]  s1_d_reg [3];
    logic [DIAMW-1:0]      s1_diam_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_oc_reg[i] <= oc_next[i];
                s1_d_reg[i]  <= d_in[i];
            end
            s1_diam_reg <= diameter;
        end
    end

    // ---------------- stage 2: component products ----------------
    logic signed [2*CW-1:0]  dd_next [3];
    logic signed [ODW-1:0]   od_next [3];
    logic signed [2*OCW-1:0] oo_next [3];
    logic [DSQW-1:0]         dsq_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dd_next[i] = s1_d_reg[i] * s1_d_reg[i];
            od_next[i] = s1_oc_reg[i] * s1_d_reg[i];
            oo_next[i] = s1_oc_reg[i] * s1_oc_reg[i];
        end
        dsq_next = s1_diam_reg * s1_diam_reg;
    end

    logic                  s2_v_reg;
    logic [2*CW-1:0]       s2_dd_reg [3];
    logic signed [ODW-1:0] s2_od_reg [3];
    logic [2*OCW-1:0]      s2_oo_reg [3];
    logic [DSQW-1:0]       s2_dsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_dd_reg[i] <= dd_next[i];
                s2_od_reg[i] <= od_next[i];
                s2_oo_reg[i] <= oo_next[i];
            end
            s2_dsq_reg <= dsq_next;
        end
    end

    // ---------------- stage 3: dot products ----------------
    logic                 s3_v_reg;
    logic [AW-1:0]        s3_a_reg;
    logic signed [HW-1:0] s3_h_reg;
    logic [OOW-1:0]       s3_oo_reg;
    logic [DSQW-1:0]      s3_dsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_a_reg   <= AW'(s2_dd_reg[0]) + AW'(s2_dd_reg[1]) + AW'(s2_dd_reg[2]);
            s3_h_reg   <= HW'(s2_od_reg[0]) + HW'(s2_od_reg[1]) + HW'(s2_od_reg[2]);
            s3_oo_reg  <= OOW'(s2_oo_reg[0]) + OOW'(s2_oo_reg[1]) + OOW'(s2_oo_reg[2]);
            s3_dsq_reg <= s2_dsq_reg;
        end
    end

    // ---------------- stage 4: |h| and its sign ----------------
    logic signed [HW-1:0] neg_h;
    logic                 xpos_next;

    assign neg_h     = -s3_h_reg;
    assign xpos_next = s3_h_reg[HW-1] || (s3_h_reg == '0);

    logic            s4_v_reg;
    logic            s4_xpos_reg;
    logic            s4_anz_reg;
    logic [HMW-1:0]  s4_hm_reg;
    logic [AW-1:0]   s4_a_reg;
    logic [OOW-1:0]  s4_oo_reg;
    logic [DSQW-1:0] s4_dsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_xpos_reg <= xpos_next;
            s4_anz_reg  <= s3_a_reg != '0;
            s4_hm_reg   <= xpos_next ? neg_h[HMW-1:0] : s3_h_reg[HMW-1:0];
            s4_a_reg    <= s3_a_reg;
            s4_oo_reg   <= s3_oo_reg;
            s4_dsq_reg  <= s3_dsq_reg;
        end
    end

    // ---------------- stages 5-7: wide products ----------------
    logic [MPW-1:0] hm2;
    logic [MPW-1:0] adsq;
    logic [MPW-1:0] aoo;

    rsi_mul u_mul_hh
    (
        .clk (clk),
        .en  (en),
        .a   (MW'(s4_hm_reg)),
        .b   (MW'(s4_hm_reg)),
        .p   (hm2)
    );

    rsi_mul u_mul_ad
    (
        .clk (clk),
        .en  (en),
        .a   (MW'(s4_a_reg)),
        .b   (MW'(s4_dsq_reg)),
        .p   (adsq)
    );

    rsi_mul u_mul_ao
    (
        .clk (clk),
        .en  (en),
        .a   (MW'(s4_a_reg)),
        .b   (MW'(s4_oo_reg)),
        .p   (aoo)
    );

    rsi_side_t s4_side;
    logic      md_v_reg [3];
    rsi_side_t md_side_reg [3];

    assign s4_side = '{ok: s4_anz_reg, xpos: s4_xpos_reg, hm: s4_hm_reg, a: s4_a_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                md_v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            md_v_reg[0] <= s4_v_reg;
            md_v_reg[1] <= md_v_reg[0];
            md_v_reg[2] <= md_v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            md_side_reg[0] <= s4_side;
            md_side_reg[1] <= md_side_reg[0];
            md_side_reg[2] <= md_side_reg[1];
        end
    end

    // ---------------- stage 8: both sides of the discriminant ----------------
    logic          s5_v_reg;
    logic [QW-1:0] s5_p_reg;
    logic [QW-1:0] s5_m_reg;
    rsi_side_t     s5_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_v_reg <= md_v_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_p_reg    <= (QW'(hm2) << 2) + QW'(adsq);
            s5_m_reg    <= QW'(aoo) << 2;
            s5_side_reg <= md_side_reg[2];
        end
    end

    // ---------------- stage 9: discriminant ----------------
    logic          s6_v_reg;
    logic [QW-1:0] s6_q_reg;
    rsi_side_t     s6_side_reg;
    rsi_side_t     s6_side_next;

    always_comb
    begin
        s6_side_next    = s5_side_reg;
        s6_side_next.ok = s5_side_reg.ok && (s5_p_reg >= s5_m_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s6_v_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_q_reg    <= s5_p_reg - s5_m_reg;
            s6_side_reg <= s6_side_next;
        end
    end

    // ---------------- square root ----------------
    logic          sq_v;
    logic [RW-1:0] sq_root;
    rsi_side_t     sq_side;

    rsi_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_v_reg),
        .in_rad    ({s6_q_reg, {(2*FB){1'b0}}}),
        .in_side   (s6_side_reg),
        .out_valid (sq_v),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // ---------------- root select, first stage: (eps+1)*2a halves ----------------
    logic [EPS_W:0]    eps1;
    logic [DENW-1:0]   den_next;

    assign eps1     = {1'b0, eps_reg} + (EPS_W+1)'(1);
    assign den_next = {sq_side.a, 1'b0};

    logic                  e1_v_reg;
    logic                  e1_ok_reg;
    logic                  e1_xpos_reg;
    logic [NW-1:0]         e1_n_reg;
    logic [RW-1:0]         e1_r_reg;
    logic [DENW-1:0]       e1_den_reg;
    logic [EPS_W+DLO:0]    e1_tl_reg;
    logic [EPS_W+DHI:0]    e1_th_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            e1_v_reg <= sq_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_ok_reg   <= sq_side.ok;
            e1_xpos_reg <= sq_side.xpos;
            e1_n_reg    <= {sq_side.hm, {(FB+1){1'b0}}};
            e1_r_reg    <= sq_root;
            e1_den_reg  <= den_next;
            e1_tl_reg   <= eps1 * den_next[DLO-1:0];
            e1_th_reg   <= eps1 * den_next[DENW-1:DLO];
        end
    end

    // ---------------- second stage: candidate numerators ----------------
    logic [NUMW-1:0] n_x;
    logic [NUMW-1:0] r_x;

    assign n_x = NUMW'(e1_n_reg);
    assign r_x = NUMW'(e1_r_reg);

    logic             e2_v_reg;
    logic             e2_ok_reg;
    logic             e2_t1ok_reg;
    logic             e2_t2ok_reg;
    logic [THW-1:0]   e2_thr_reg;
    logic [NUMW-1:0]  e2_t1_reg;
    logic [NUMW-1:0]  e2_t2_reg;
    logic [DENW-1:0]  e2_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            e2_v_reg <= e1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e2_ok_reg   <= e1_ok_reg;
            e2_thr_reg  <= THW'(e1_tl_reg) + (THW'(e1_th_reg) << DLO);
            e2_t1_reg   <= n_x - r_x;
            e2_t2_reg   <= e1_xpos_reg ? n_x + r_x : r_x - n_x;
            e2_t1ok_reg <= e1_xpos_reg && (n_x > r_x);
            e2_t2ok_reg <= e1_xpos_reg || (r_x > n_x);
            e2_den_reg  <= e1_den_reg;
        end
    end

    // ---------------- third stage: near root wins when its quotient clears epsilon ----------------
    logic use_near;

    assign use_near = e2_t1ok_reg && (CMPW'(e2_t1_reg) >= CMPW'(e2_thr_reg));

    logic            e3_v_reg;
    logic            e3_ok_reg;
    logic [NUMW-1:0] e3_num_reg;
    logic [DENW-1:0] e3_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            e3_v_reg <= e2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e3_ok_reg  <= e2_ok_reg && (use_near || e2_t2ok_reg);
            e3_num_reg <= use_near ? e2_t1_reg : e2_t2_reg;
            e3_den_reg <= e2_den_reg;
        end
    end

    // ---------------- quotient: saturation check, then one bit per stage ----------------
    logic             div_v_reg   [QTW+1];
    logic             div_ok_reg  [QTW+1];
    logic             div_sat_reg [QTW+1];
    logic [DVW-1:0]   div_rem_reg [QTW+1];
    logic [QTW-1:0]   div_q_reg   [QTW+1];
    logic [DENW-1:0]  div_den_reg [QTW+1];

    for (genvar g = 0; g <= QTW; g++)
    begin : g_div
        logic           v_p;
        logic           ok_p;
        logic           sat_p;
        logic [DVW-1:0] rem_p;
        logic [QTW-1:0] q_p;
        logic [DENW-1:0] den_p;
        logic           sat_n;
        logic [DVW-1:0] rem_n;
        logic [QTW-1:0] q_n;

        if (g == 0)
        begin : g_sat
            logic [DVW-1:0] dtop;

            assign v_p   = e3_v_reg;
            assign ok_p  = e3_ok_reg;
            assign sat_p = 1'b0;
            assign rem_p = DVW'(e3_num_reg);
            assign q_p   = '0;
            assign den_p = e3_den_reg;
            assign dtop  = DVW'(den_p) << QTW;
            assign sat_n = rem_p >= dtop;
            assign rem_n = rem_p;
            assign q_n   = '0;
        end
        else
        begin : g_bit
            logic [DVW-1:0] dsh;
            logic           ge;

            assign v_p   = div_v_reg[g-1];
            assign ok_p  = div_ok_reg[g-1];
            assign sat_p = div_sat_reg[g-1];
            assign rem_p = div_rem_reg[g-1];
            assign q_p   = div_q_reg[g-1];
            assign den_p = div_den_reg[g-1];
            assign dsh   = DVW'(den_p) << (QTW - g);
            assign ge    = rem_p >= dsh;
            assign sat_n = sat_p;
            assign rem_n = ge ? rem_p - dsh : rem_p;
            assign q_n   = {q_p[QTW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                div_v_reg[g] <= v_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_ok_reg[g]  <= ok_p;
                div_sat_reg[g] <= sat_n;
                div_rem_reg[g] <= rem_n;
                div_q_reg[g]   <= q_n;
                div_den_reg[g] <= den_p;
            end
        end
    end

    // ---------------- result ----------------
    logic          fin_v;
    logic          fin_hit;
    logic [CW-1:0] fin_dist;

    assign fin_v   = div_v_reg[QTW];
    assign fin_hit = div_ok_reg[QTW]
                     && (div_sat_reg[QTW] || (div_q_reg[QTW] > QTW'(eps_reg)));

    always_comb
    begin
        if (!fin_hit)
        begin
            fin_dist = MISS_DIST;
        end
        else if (div_sat_reg[QTW])
        begin
            fin_dist = MAX_DIST;
        end
        else
        begin
            fin_dist = {1'b0, div_q_reg[QTW]};
        end
    end

    // ---------------- output register with skid ----------------
    logic          out_v_reg;
    logic          out_hit_reg;
    logic [CW-1:0] out_dist_reg;
    logic          skid_v_reg;
    logic          skid_hit_reg;
    logic [CW-1:0] skid_dist_reg;
    logic          load_out;

    assign en        = !skid_v_reg;
    assign req_stall = skid_v_reg;
    assign load_out  = !out_v_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_v_reg  <= skid_v_reg || (en && fin_v);
            skid_v_reg <= 1'b0;
        end
        else if (en && fin_v)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_hit_reg  <= skid_v_reg ? skid_hit_reg : fin_hit;
            out_dist_reg <= skid_v_reg ? skid_dist_reg : fin_dist;
        end
        else if (en && fin_v)
        begin
            skid_hit_reg  <= fin_hit;
            skid_dist_reg <= fin_dist;
        end
    end

    assign rsp_valid = out_v_reg;
    assign hit       = out_hit_reg;
    assign distance  = out_dist_reg;

endmodule

/* sv/rsi_mul.sv */
// wide unsigned multiplier, partial products over three register stages
module rsi_mul import rsi_pkg::*;
(
    input  logic           clk,
    input  logic           en,
    input  logic [MW-1:0]  a,
    input  logic [MW-1:0]  b,
    output logic [MPW-1:0] p
);

    localparam int PCW = MNCH * MCH;
    localparam int PPW = 2 * PCW;

    logic [PCW-1:0]   a_pad;
    logic [PCW-1:0]   b_pad;
    logic [2*MCH-1:0] pp_reg [MNCH*MNCH];
    logic [PPW-1:0]   row_reg [MNCH];
    logic [PPW-1:0]   row_next [MNCH];
    logic [PPW-1:0]   p_reg;
    logic [PPW-1:0]   p_next;

    assign a_pad = PCW'(a);
    assign b_pad = PCW'(b);

    always_comb
    begin
        for (int i = 0; i < MNCH; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < MNCH; j++)
            begin
                row_next[i] = row_next[i] + (PPW'(pp_reg[i*MNCH+j]) << (j * MCH));
            end
        end
    end

    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < MNCH; i++)
        begin
            p_next = p_next + (row_reg[i] << (i * MCH));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < MNCH; i++)
            begin
                for (int j = 0; j < MNCH; j++)
                begin
                    pp_reg[i*MNCH+j] <= a_pad[i*MCH +: MCH] * b_pad[j*MCH +: MCH];
                end
                row_reg[i] <= row_next[i];
            end
            p_reg <= p_next;
        end
    end

    assign p = p_reg[MPW-1:0];

endmodule

/* sv/rsi_sqrt.sv */
// pipelined integer square root, one result bit per stage
module rsi_sqrt import rsi_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [TW-1:0]  in_rad,
    input  rsi_side_t      in_side,
    output logic           out_valid,
    output logic [RW-1:0]  out_root,
    output rsi_side_t      out_side
);

    logic            v_reg    [RW];
    logic [TW-1:0]   rad_reg  [RW];
    logic [RMW-1:0]  rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    rsi_side_t       side_reg [RW];

    for (genvar g = 0; g < RW; g++)
    begin : g_stage
        logic           v_p;
        logic [TW-1:0]  rad_p;
        logic [RMW-1:0] rem_p;
        logic [RW-1:0]  root_p;
        rsi_side_t      side_p;
        logic [RMW-1:0] rem_sh;
        logic [RMW-1:0] trial;
        logic           ge;

        if (g == 0)
        begin : g_first
            assign v_p    = in_valid;
            assign rad_p  = in_rad;
            assign rem_p  = '0;
            assign root_p = '0;
            assign side_p = in_side;
        end
        else
        begin : g_next
            assign v_p    = v_reg[g-1];
            assign rad_p  = rad_reg[g-1];
            assign rem_p  = rem_reg[g-1];
            assign root_p = root_reg[g-1];
            assign side_p = side_reg[g-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign rem_sh = {rem_p[RMW-3:0], rad_p[TW-1 -: 2]};
        assign trial  = {root_p, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g] <= v_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[g]  <= rad_p << 2;
                rem_reg[g]  <= ge ? rem_sh - trial : rem_sh;
                root_reg[g] <= {root_p[RW-2:0], ge};
                side_reg[g] <= side_p;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

/* sv/rsi_checker.sv */
// port-level checks for the intersection block, bound to the top level
module rsi_checker import rsi_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_stall,
    input logic                 rsp_valid,
    input logic                 rsp_stall,
    input logic                 hit,
    input logic signed [CW-1:0] distance
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(hit) && $stable(distance))
        else $error("response changed while stalled");

    // a miss always reports minus one in Q16.16
    a_miss_dist: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !hit |-> distance == MISS_DIST)
        else $error("miss with wrong distance");

    // a hit lies strictly in front of the origin
    a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && hit |-> !distance[CW-1] && (distance != '0))
        else $error("hit distance not positive");

    // input backpressure only starts after a held response
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
        else $error("request stall without held response");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);
